@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent checks, disabled while in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bdq_pkg.sv @@
// ---------------------------------------------------------------------------
// bdq_pkg
// opcodes, status codes, field widths and result type of the deque block
// ---------------------------------------------------------------------------
package bdq_pkg;

  // field widths
  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int POS_W  = 6;
  localparam int OCC_W  = 7;

  // stream bus widths, result data padded to whole bytes
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - VAL_W - OCC_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // one result beat
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] removed_value;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

endpackage

@@ hdl/bounded_deque_with_search.sv @@
// ---------------------------------------------------------------------------
// bounded_deque_with_search
// Deque of signed 32-bit values in a ring store, with front-to-back search.
// Input channel: in_tuser carries the opcode, in_tdata the value. Each beat
// gives exactly one result beat on the output channel (status in out_tuser).
// Push, clear, unused opcodes and rejected operations go from idle straight
// to the response state; pops pass through one store read; a search steps
// from the front and stops at the first match or after the last element.
// The result enters the output register as the sequencer returns to idle.
// Cost per item is set by the single store read port and the one equality
// comparator, which the search steps through one entry per cycle.
// The block takes one operation at a time; in_tready drops while it works.
// A finished result sits in the output register, so the next operation is
// accepted while that result waits; if out_tready stays low the block stalls
// once its next result is also ready. Reset empties the deque (count and
// front index zero); store contents are not cleared and need no sweep.
// ---------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // operation beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bdq_pkg::VAL_W-1:0]           in_tdata,   // [31:0] value
  input  logic [bdq_pkg::OP_W-1:0]            in_tuser,   // [2:0] opcode
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bdq_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [5:0] position,
                                                          // [37:6] removed_value,
                                                          // [44:38] occupancy,
                                                          // [47:45] zero
  output logic [bdq_pkg::ST_W-1:0]            out_tuser   // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                        res_valid, res_ready;
  bdq_pkg::res_t               res;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [bdq_pkg::VAL_W-1:0]   ram_wdata, ram_rdata;

  logic                        out_valid_r, out_valid_nxt;
  logic [bdq_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [bdq_pkg::ST_W-1:0]    out_user_r, out_user_nxt;

  // element store
  bdq_ram #(
    .WIDTH (bdq_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and compare unit
  bdq_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register, loads when empty or draining this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{bdq_pkg::OUT_PAD_W{1'b0}}, res.occupancy, res.removed_value,
                       res.position};
      out_user_nxt  = res.status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hdl/bdq_ram.sv @@
// ---------------------------------------------------------------------------
// bdq_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bdq_core.sv @@
// ---------------------------------------------------------------------------
// bdq_core
// ring pointers, operation sequencer and the shared equality compare unit
// that walks the store one entry per cycle during a search
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_core #(
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // operation beat
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdq_pkg::OP_W-1:0]      in_op,
  input  logic [bdq_pkg::VAL_W-1:0]     in_value,
  // result beat
  output logic                          res_valid,
  input  logic                          res_ready,
  output bdq_pkg::res_t                 res,
  // element store
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [bdq_pkg::VAL_W-1:0]     ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [bdq_pkg::VAL_W-1:0]     ram_rdata
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PEW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;
  localparam int OEW = (CW > bdq_pkg::OCC_W) ? CW : bdq_pkg::OCC_W;

  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDATA = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [AW-1:0]               front_r, front_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [bdq_pkg::VAL_W-1:0]   val_r, val_nxt;
  bdq_pkg::res_t               res_r, res_nxt;

  logic                        full, empty, hit, scan_last;
  logic [AW-1:0]               front_prev, front_next, idx_next;
  logic [AW:0]                 back_sum, last_sum;
  logic [AW-1:0]               back_addr, last_addr;
  logic [PEW-1:0]              k_ext;
  logic [OEW-1:0]              occ_ext;

  // ring arithmetic
  assign full       = (count_r == DEPTH_CNT);
  assign empty      = (count_r == '0);
  assign front_prev = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_next = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign idx_next   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign back_sum   = {1'b0, front_r} + (AW + 1)'(count_r);
  assign last_sum   = {1'b0, front_r} + (AW + 1)'(count_r - 1'b1);
  assign back_addr  = (back_sum >= DEPTH_EXT) ? AW'(back_sum - DEPTH_EXT) : back_sum[AW-1:0];
  assign last_addr  = (last_sum >= DEPTH_EXT) ? AW'(last_sum - DEPTH_EXT) : last_sum[AW-1:0];

  // shared compare unit: one stored entry against the key per cycle
  assign hit       = (ram_rdata == val_r);
  assign scan_last = ((k_r + 1'b1) == count_r);
  assign k_ext     = PEW'(k_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = front_prev;
    ram_wdata = in_value;
    ram_raddr = front_r;
    occ_ext   = OEW'(count_r);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_nxt               = in_value;
          res_nxt.status        = bdq_pkg::ST_OK;
          res_nxt.position      = '0;
          res_nxt.removed_value = '0;
          state_nxt             = S_RESP;
          unique case (in_op)
            bdq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_nxt.status = bdq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_prev;
                front_nxt = front_prev;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_nxt.status = bdq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_addr;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_nxt.status = bdq_pkg::ST_EMPTY;
              end else begin
                ram_raddr = front_r;
                front_nxt = front_next;
                count_nxt = count_r - 1'b1;
                state_nxt = S_RDATA;
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_nxt.status = bdq_pkg::ST_EMPTY;
              end else begin
                ram_raddr = last_addr;
                count_nxt = count_r - 1'b1;
                state_nxt = S_RDATA;
              end
            end
            bdq_pkg::OP_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            bdq_pkg::OP_SEARCH: begin
              if (empty) begin
                res_nxt.status = bdq_pkg::ST_EMPTY;
              end else begin
                ram_raddr = front_r;
                idx_nxt   = front_r;
                k_nxt     = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          occ_ext           = OEW'(count_nxt);
          res_nxt.occupancy = occ_ext[bdq_pkg::OCC_W-1:0];
        end
      end

      // popped element arrives from the store
      S_RDATA: begin
        res_nxt.removed_value = ram_rdata;
        state_nxt             = S_RESP;
      end

      // walk from front to back, next read issued while comparing this one
      S_SCAN: begin
        ram_raddr = idx_next;
        if (hit) begin
          res_nxt.status   = bdq_pkg::ST_OK;
          res_nxt.position = k_ext[bdq_pkg::POS_W-1:0];
          state_nxt        = S_RESP;
        end else if (scan_last) begin
          res_nxt.status = bdq_pkg::ST_NOTFOUND;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_next;
          k_nxt   = k_r + 1'b1;
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      k_r     <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

  // checks
  `BDQ_ASSERT(a_count_bound, count_r <= DEPTH_CNT, "element count above depth")
  `BDQ_ASSERT(a_scan_in_range, (state_r != S_SCAN) || (k_r < count_r), "scan ran past last element")
  `BDQ_ASSERT_NEXT(a_push_grows, in_valid && in_ready && !full && (in_op == bdq_pkg::OP_PUSH_FRONT || in_op == bdq_pkg::OP_PUSH_BACK), count_r == $past(count_r) + 1'b1, "push did not grow the count")
  `BDQ_ASSERT_NEXT(a_clear_resets, in_valid && in_ready && (in_op == bdq_pkg::OP_CLEAR), (count_r == '0) && (front_r == '0), "clear left elements behind")

endmodule
